// File: sv/bdel_pkg.sv
package bdel_pkg;

    localparam logic [2:0] OP_INS_FRONT = 3'd0;
    localparam logic [2:0] OP_INS_BACK  = 3'd1;
    localparam logic [2:0] OP_DELETE    = 3'd2;
    localparam logic [2:0] OP_DUMP      = 3'd3;
    localparam logic [2:0] OP_REVERSE   = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] item;
        logic [4:0]         position;
        logic               last;
    } t_out;

    // controller to datapath
    typedef struct packed {
        logic       load_in;
        logic       ins_do;
        logic       del_commit;
        logic       flip;
        logic       idx_clr;
        logic       idx_inc;
        logic       k_load;
        logic       k_inc;
        logic       rd_logical;
        logic       rd_next;
        logic       wr_move;
        logic       emit_resp;
        logic       emit_dump;
        logic [1:0] resp_status;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [2:0] op;
        logic       full;
        logic       empty;
        logic       match;
        logic       idx_last;
        logic       has_tail;
        logic       move_more;
        logic       out_free;
    } t_sts;

endpackage

// File: sv/bdel_ram.sv
module bdel_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/bdel_dp.sv
module bdel_dp #(
    parameter int DEPTH = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bdel_pkg::t_in  i_in,
    input  logic           i_out_stall,
    input  bdel_pkg::t_cmd i_cmd,
    output bdel_pkg::t_sts o_sts,
    output logic           o_out_valid,
    output bdel_pkg::t_out o_out
);
    import bdel_pkg::*;

    localparam int SW = $clog2(DEPTH);
    localparam int EW = SW + 1;
    localparam logic [EW-1:0] DEPTH_E   = EW'(DEPTH);
    localparam logic [SW-1:0] LAST_SLOT = SW'(DEPTH - 1);

    // fold a sum of two ring offsets back into the ring
    function automatic logic [SW-1:0] wrap(input logic [EW-1:0] s);
        if (s >= DEPTH_E) begin
            return SW'(s - DEPTH_E);
        end
        return s[SW-1:0];
    endfunction

    logic [EW-1:0]      r_count;
    logic [SW-1:0]      r_front;
    logic               r_rev;
    logic [SW-1:0]      r_idx;
    logic [SW-1:0]      r_k;
    logic [2:0]         r_op;
    logic signed [31:0] r_val;
    logic               r_out_valid;
    t_out               r_out;

    logic [EW-1:0] front_e, idx_e, k_e, log_off;
    logic [SW-1:0] log_slot, next_slot, k_slot, end_slot, front_m1;
    logic          at_start;
    logic          out_free;
    logic          ram_we, ram_re;
    logic [SW-1:0] ram_waddr, ram_raddr;
    logic [31:0]   ram_wdata, ram_rdata;
    logic [31:0]   idx_wide;

    assign front_e   = {1'b0, r_front};
    assign idx_e     = {1'b0, r_idx};
    assign k_e       = {1'b0, r_k};
    assign log_off   = r_rev ? (r_count - EW'(1) - idx_e) : idx_e;
    assign log_slot  = wrap(front_e + log_off);
    assign next_slot = wrap(front_e + k_e + EW'(1));
    assign k_slot    = wrap(front_e + k_e);
    assign end_slot  = wrap(front_e + r_count);
    assign front_m1  = (r_front == '0) ? LAST_SLOT : r_front - SW'(1);
    assign at_start  = (r_op == OP_INS_FRONT) != r_rev;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign idx_wide  = 32'(r_idx);

    assign ram_re    = i_cmd.rd_logical || i_cmd.rd_next;
    assign ram_raddr = i_cmd.rd_next ? next_slot : log_slot;
    assign ram_we    = i_cmd.ins_do || i_cmd.wr_move;
    assign ram_waddr = i_cmd.ins_do ? (at_start ? front_m1 : end_slot) : k_slot;
    assign ram_wdata = i_cmd.ins_do ? r_val : ram_rdata;

    bdel_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_front     <= '0;
            r_rev       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.ins_do) begin
                r_count <= r_count + EW'(1);
                if (at_start) begin
                    r_front <= front_m1;
                end
            end
            if (i_cmd.del_commit) begin
                r_count <= r_count - EW'(1);
            end
            if (i_cmd.flip) begin
                r_rev <= !r_rev;
            end
            if (i_cmd.emit_resp || i_cmd.emit_dump) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op  <= i_in.op;
            r_val <= i_in.value;
        end
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + SW'(1);
        end
        if (i_cmd.k_load) begin
            r_k <= log_off[SW-1:0];
        end else if (i_cmd.k_inc) begin
            r_k <= r_k + SW'(1);
        end
        if (i_cmd.emit_resp) begin
            r_out.status   <= i_cmd.resp_status;
            r_out.item     <= '0;
            r_out.position <= '0;
            r_out.last     <= 1'b1;
        end else if (i_cmd.emit_dump) begin
            r_out.status   <= ST_OK;
            r_out.item     <= $signed(ram_rdata);
            r_out.position <= idx_wide[4:0];
            r_out.last     <= (idx_e + EW'(1)) == r_count;
        end
    end

    assign o_sts.op        = r_op;
    assign o_sts.full      = r_count == DEPTH_E;
    assign o_sts.empty     = r_count == '0;
    assign o_sts.match     = ram_rdata == r_val;
    assign o_sts.idx_last  = (idx_e + EW'(1)) == r_count;
    assign o_sts.has_tail  = (log_off + EW'(1)) < r_count;
    assign o_sts.move_more = (k_e + EW'(2)) < r_count;
    assign o_sts.out_free  = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_E)
        else $error("list count beyond depth");

    a_front_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_front} < DEPTH_E)
        else $error("front slot outside ring");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_resp || i_cmd.emit_dump) |-> out_free)
        else $error("result overwrites a held beat");

    a_ins_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins_do |-> (r_count < DEPTH_E))
        else $error("insert into a full list");

endmodule

// File: sv/bdel_ctrl.sv
module bdel_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  bdel_pkg::t_sts i_sts,
    output bdel_pkg::t_cmd o_cmd,
    output logic           o_in_stall
);
    import bdel_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_SREAD  = 4'd2;
    localparam logic [3:0] S_SCMP   = 4'd3;
    localparam logic [3:0] S_MREAD  = 4'd4;
    localparam logic [3:0] S_MWRITE = 4'd5;
    localparam logic [3:0] S_DREAD  = 4'd6;
    localparam logic [3:0] S_DOUT   = 4'd7;
    localparam logic [3:0] S_RESP   = 4'd8;

    logic [3:0] r_state, n_state;
    logic [1:0] r_status, n_status;
    t_cmd       cmd;

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        cmd      = '0;
        cmd.resp_status = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_in = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.op) inside
                    OP_INS_FRONT, OP_INS_BACK: begin
                        if (i_sts.full) begin
                            n_status = ST_FULL;
                        end else begin
                            cmd.ins_do = 1'b1;
                            n_status   = ST_OK;
                        end
                        n_state = S_RESP;
                    end
                    OP_DELETE: begin
                        if (i_sts.empty) begin
                            n_status = ST_EMPTY;
                            n_state  = S_RESP;
                        end else begin
                            cmd.idx_clr = 1'b1;
                            n_state     = S_SREAD;
                        end
                    end
                    OP_DUMP: begin
                        if (i_sts.empty) begin
                            n_status = ST_EMPTY;
                            n_state  = S_RESP;
                        end else begin
                            cmd.idx_clr = 1'b1;
                            n_state     = S_DREAD;
                        end
                    end
                    OP_REVERSE: begin
                        if (i_sts.empty) begin
                            n_status = ST_EMPTY;
                        end else begin
                            cmd.flip = 1'b1;
                            n_status = ST_OK;
                        end
                        n_state = S_RESP;
                    end
                    default: begin
                        n_status = ST_OK;
                        n_state  = S_RESP;
                    end
                endcase
            end
            S_SREAD: begin
                cmd.rd_logical = 1'b1;
                n_state        = S_SCMP;
            end
            S_SCMP: begin
                if (i_sts.match) begin
                    if (i_sts.has_tail) begin
                        cmd.k_load = 1'b1;
                        n_state    = S_MREAD;
                    end else begin
                        cmd.del_commit = 1'b1;
                        n_status       = ST_OK;
                        n_state        = S_RESP;
                    end
                end else if (i_sts.idx_last) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_RESP;
                end else begin
                    cmd.idx_inc = 1'b1;
                    n_state     = S_SREAD;
                end
            end
            S_MREAD: begin
                cmd.rd_next = 1'b1;
                n_state     = S_MWRITE;
            end
            S_MWRITE: begin
                // pull the next element down one slot
                cmd.wr_move = 1'b1;
                if (i_sts.move_more) begin
                    cmd.k_inc = 1'b1;
                    n_state   = S_MREAD;
                end else begin
                    cmd.del_commit = 1'b1;
                    n_status       = ST_OK;
                    n_state        = S_RESP;
                end
            end
            S_DREAD: begin
                cmd.rd_logical = 1'b1;
                n_state        = S_DOUT;
            end
            S_DOUT: begin
                // hold the read data until the output beat is free
                if (i_sts.out_free) begin
                    cmd.emit_dump = 1'b1;
                    if (i_sts.idx_last) begin
                        n_state = S_IDLE;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        n_state     = S_DREAD;
                    end
                end
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    cmd.emit_resp = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    assign o_cmd      = cmd;
    assign o_in_stall = r_state != S_IDLE;

    a_start_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_DECODE))
        else $error("accepted beat not decoded");

    a_cmp_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCMP) |-> ($past(r_state) == S_SREAD))
        else $error("compare without a fresh read");

    a_move_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MWRITE) |-> ($past(r_state) == S_MREAD))
        else $error("move without a fresh read");

    a_dump_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DOUT && $past(r_state) != S_DOUT) |-> ($past(r_state) == S_DREAD))
        else $error("dump beat without a fresh read");

endmodule

// File: sv/bounded_double_ended_list.sv
// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_stall   bdel_pkg::t_in  (op, value)
// out       output     o_out_valid / i_out_stall bdel_pkg::t_out (status, item, position, last)
//
// Insert, reverse and unused ops pass through S_DECODE and S_RESP from accept to result beat.
// Delete scans entries (read, compare), then moves each later entry down one slot (read, write);
// dump reads and emits each entry in turn; both run through the single read port of the entry RAM.
// Synchronous active-low reset clears count, front slot and direction; entries are not cleared.
// One command is in work at a time; o_in_stall is high until its last beat is loaded.
// A stalled output beat holds the sequencer in place until it is taken.
module bounded_double_ended_list #(
    parameter int DEPTH = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  bdel_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output bdel_pkg::t_out o_out
);
    import bdel_pkg::*;

    t_cmd cmd;
    t_sts sts;

    bdel_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    bdel_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule
